FILE: hdl/ntf_pkg.sv
// ntf_pkg: shared types, codes, constants and the exp2 table generator
// for the note to frequency converter. No dependencies.
package ntf_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int EXP_ROM_BITS_DEF = 6;

    // field widths
    localparam int NOTE_W     = 16;
    localparam int NOTE_INT_W = 8;
    localparam int FRAC_W     = 8;
    localparam int IDX_W      = 4;
    localparam int LOG2_W     = 16;
    localparam int STEPS_W    = 5;
    localparam int STEP_IDX_W = 4;
    localparam int PITCH_W    = 25;
    localparam int OCT_W      = 9;
    localparam int FREQ_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_EXT_W = 7;

    typedef enum logic
    {
        CMD_CONVERT = 1'b0,
        CMD_WRITE   = 1'b1
    } cmd_t;

    typedef enum logic
    {
        MODE_EQUAL = 1'b0,
        MODE_TABLE = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_TUNING_MODE = 2'd0,
        REG_STEPS       = 2'd1,
        REG_ROOT        = 2'd2
    } reg_idx_t;

    localparam mode_t              MODE_RESET  = MODE_EQUAL;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 5'd12;
    localparam logic [FREQ_W-1:0]  ROOT_RESET  = 32'd23410149;

    // equal temperament: pitch = floor(note * 64 / 3), done as
    // floor(y / 3) - 2^21 with y = note * 64 + 3 * 2^21 kept positive
    localparam logic [22:0] EQ_BIAS_Y  = 23'd6291456;
    localparam logic [23:0] EQ_RECIP   = 24'd11184811;
    localparam int          EQ_SHIFT   = 25;
    localparam logic signed [PITCH_W-1:0] EQ_BIAS_Q = 25'sd2097152;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [16:0] OCTAVE_Q16 = 17'h10000;

    // one item on its way through the step divider
    typedef struct packed
    {
        cmd_t                        cmd;
        logic [IDX_W-1:0]            idx;
        logic [LOG2_W-1:0]           log2;
        logic [FRAC_W-1:0]           frac;
        logic                        neg;
        logic [NOTE_INT_W-1:0]       mag;
        logic signed [PITCH_W-1:0]   eq_pitch;
    } ntf_item_t;

    // ratio table access for one cycle
    typedef struct packed
    {
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_addr;
        logic [LOG2_W-1:0]     wr_data;
        logic                  rd_en;
        logic [STEP_IDX_W-1:0] rd_addr0;
        logic [STEP_IDX_W-1:0] rd_addr1;
    } tbl_req_t;

    // 2^(idx / 2^bits) in Q2.30 from a truncated series of exp(x)
    function automatic logic [31:0] exp_rom_entry(input int unsigned idx,
                                                  input int unsigned bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        if (idx >= (32'd1 << bits))
            return 32'h8000_0000;
        x    = (64'(idx) * 64'(LN2_Q32)) >> bits;
        term = 64'd1 << 30;
        sum  = term;
        for (int Step = 1; Step <= 20; Step++)
        begin
            term = ((term * x) >> 32) / 64'(Step);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

FILE: hdl/ntf_div.sv
// ntf_div: pipelined restoring divider, one quotient bit per stage,
// splitting the note's integer magnitude by steps per octave. Uses ntf_pkg.
module ntf_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  ntf_pkg::ntf_item_t                in_item,
    input  logic [ntf_pkg::STEPS_W-1:0]       divisor,
    output logic                              out_valid,
    output ntf_pkg::ntf_item_t                out_item,
    output logic [ntf_pkg::NOTE_INT_W-1:0]    out_quo,
    output logic [ntf_pkg::STEPS_W-1:0]       out_rem
);
    import ntf_pkg::*;

    localparam int STAGES = NOTE_INT_W;

    logic                  valid_reg [STAGES];
    ntf_item_t             item_reg  [STAGES];
    logic [STAGES-1:0]     quo_reg   [STAGES];
    logic [STEPS_W-1:0]    rem_reg   [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic               v_in;
        ntf_item_t          it_in;
        logic [STAGES-1:0]  q_in;
        logic [STEPS_W-1:0] r_in;
        logic [STEPS_W:0]   r_w;
        logic               fit;

        if (g == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign it_in = in_item;
            assign q_in  = '0;
            assign r_in  = '0;
        end
        else
        begin : g_next
            assign v_in  = valid_reg[g-1];
            assign it_in = item_reg[g-1];
            assign q_in  = quo_reg[g-1];
            assign r_in  = rem_reg[g-1];
        end

        // partial remainder stays below the divisor, so one compare-subtract
        assign r_w = {r_in, it_in.mag[STAGES-1-g]};
        assign fit = (r_w >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (adv)
                valid_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                item_reg[g] <= it_in;
                quo_reg[g]  <= {q_in[STAGES-2:0], fit};
                rem_reg[g]  <= fit ? STEPS_W'(r_w - {1'b0, divisor}) : r_w[STEPS_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];

endmodule

FILE: hdl/ntf_table.sv
// ntf_table: ratio table memory, one write port and two registered read ports.
// Uses ntf_pkg for the request struct.
module ntf_table
#(
    parameter int TABLE_DEPTH = ntf_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  ntf_pkg::tbl_req_t             req,
    output logic [ntf_pkg::LOG2_W-1:0]    rd_data0,
    output logic [ntf_pkg::LOG2_W-1:0]    rd_data1
);
    import ntf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [LOG2_W-1:0]     mem [TABLE_DEPTH];
    logic [ADDR_EXT_W-1:0] wr_ext;
    logic [ADDR_EXT_W-1:0] rd_ext0;
    logic [ADDR_EXT_W-1:0] rd_ext1;
    logic                  wr_in_range;

    assign wr_ext      = ADDR_EXT_W'(req.wr_addr);
    assign rd_ext0     = ADDR_EXT_W'(req.rd_addr0);
    assign rd_ext1     = ADDR_EXT_W'(req.rd_addr1);
    // writes past the table are dropped
    assign wr_in_range = (wr_ext < ADDR_EXT_W'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
            mem[wr_ext[AW-1:0]] <= req.wr_data;
        if (req.rd_en)
        begin
            rd_data0 <= mem[rd_ext0[AW-1:0]];
            rd_data1 <= mem[rd_ext1[AW-1:0]];
        end
    end

endmodule

FILE: hdl/ntf_exp2.sv
// ntf_exp2: pitch to frequency, exp2 table with linear interpolation,
// root multiply and shift with saturation, ending in the output register. Uses ntf_pkg.
module ntf_exp2
#(
    parameter int EXP_ROM_BITS = ntf_pkg::EXP_ROM_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  ntf_pkg::cmd_t                       in_cmd,
    input  logic signed [ntf_pkg::PITCH_W-1:0]  in_pitch,
    input  logic [ntf_pkg::FREQ_W-1:0]          root,
    output logic                                out_valid,
    output logic [ntf_pkg::FREQ_W-1:0]          out_freq,
    output logic                                out_sat
);
    import ntf_pkg::*;

    localparam int FB    = 16 - EXP_ROM_BITS;
    localparam int ROM_N = 1 << EXP_ROM_BITS;

    logic [31:0] rom_w [ROM_N+1];

    for (genvar g = 0; g <= ROM_N; g++)
    begin : g_rom
        assign rom_w[g] = exp_rom_entry(g, EXP_ROM_BITS);
    end

    // table lookup and slope product
    logic [EXP_ROM_BITS-1:0] ri;
    logic [EXP_ROM_BITS:0]   ri_lo;
    logic [EXP_ROM_BITS:0]   ri_hi;
    logic [FB-1:0]           sub;
    logic [31:0]             rom_a;
    logic [31:0]             rom_b;
    logic [31+FB:0]          dprod;

    assign ri    = in_pitch[15:FB];
    assign sub   = in_pitch[FB-1:0];
    assign ri_lo = {1'b0, ri};
    assign ri_hi = ri_lo + 1'b1;
    assign rom_a = rom_w[ri_lo];
    assign rom_b = rom_w[ri_hi];
    assign dprod = (32+FB)'(rom_b - rom_a) * (32+FB)'(sub);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    cmd_t                     cmd1_reg, cmd2_reg, cmd3_reg;
    logic signed [OCT_W-1:0]  k1_reg, k2_reg, k3_reg;
    logic [31:0]              a1_reg;
    logic [31+FB:0]           dprod1_reg;
    logic [31:0]              mant2_reg;
    logic [63:0]              prod3_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic                     sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // final shift by the octave and clamp
    logic signed [OCT_W:0] rdist;
    logic [OCT_W:0]        ldist;
    logic [63:0]           shr;
    logic [63:0]           hi_part;
    logic [FREQ_W-1:0]     freq_next;
    logic                  sat_next;

    assign rdist = 10'sd30 - $signed({k3_reg[OCT_W-1], k3_reg});
    assign ldist = -rdist;

    always_comb
    begin
        freq_next = '0;
        sat_next  = 1'b0;
        shr       = prod3_reg >> rdist[7:0];
        hi_part   = prod3_reg >> (7'd32 - ldist[6:0]);
        if (cmd3_reg == CMD_WRITE)
        begin
            freq_next = '0;
            sat_next  = 1'b0;
        end
        else if (!rdist[OCT_W])
        begin
            if (shr[63:32] != '0)
            begin
                freq_next = '1;
                sat_next  = 1'b1;
            end
            else
                freq_next = shr[31:0];
        end
        else if (prod3_reg == '0)
            freq_next = '0;
        else if (ldist[6:0] >= 7'd32 || hi_part != '0)
        begin
            freq_next = '1;
            sat_next  = 1'b1;
        end
        else
            freq_next = prod3_reg[31:0] << ldist[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg   <= in_cmd;
            k1_reg     <= in_pitch[PITCH_W-1:16];
            a1_reg     <= rom_a;
            dprod1_reg <= dprod;

            cmd2_reg   <= cmd1_reg;
            k2_reg     <= k1_reg;
            mant2_reg  <= a1_reg + dprod1_reg[31+FB:FB];

            cmd3_reg   <= cmd2_reg;
            k3_reg     <= k2_reg;
            prod3_reg  <= 64'(root) * 64'(mant2_reg);

            freq_reg   <= freq_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_freq  = freq_reg;
    assign out_sat   = sat_reg;

endmodule

FILE: hdl/note_to_frequency_converter.sv
// Note to frequency converter: a Q8.8 note in, a Q0.32 phase increment out.
// Takes one item per clock when not stalled; the whole path is one pipeline that
// stalls as a unit only while the output register holds a result that is not
// taken. The ratio table is a memory written and read by the item leaving the
// eighth divider stage (up to one write and two reads per cycle), so table writes
// and lookups keep item order.
// Depends on ntf_pkg, ntf_div, ntf_table and ntf_exp2.
module note_to_frequency_converter
#(
    parameter int TABLE_DEPTH  = ntf_pkg::TABLE_DEPTH_DEF,
    parameter int EXP_ROM_BITS = ntf_pkg::EXP_ROM_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ntf_pkg::S_TDATA_W-1:0]      s_tdata,   // note, entry_index, entry_log2, zero pad
    input  logic                               s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ntf_pkg::FREQ_W-1:0]         m_tdata,   // freq
    output logic                               m_tuser,   // saturated
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ntf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ntf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ntf_pkg::*;

    // configuration registers
    mode_t              mode_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [FREQ_W-1:0]  root_reg;
    logic [STEPS_W-1:0] steps_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            steps_reg <= STEPS_RESET;
            root_reg  <= ROOT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TUNING_MODE: mode_reg  <= mode_t'(cfg_data[0]);
                REG_STEPS:       steps_reg <= cfg_data[STEPS_W-1:0];
                REG_ROOT:        root_reg  <= cfg_data[FREQ_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (steps_reg == '0)
            steps_eff = STEPS_W'(1);
        else if (int'(steps_reg) > TABLE_DEPTH)
            steps_eff = STEPS_W'(TABLE_DEPTH);
        else
            steps_eff = steps_reg;
    end

    // whole pipeline moves when the output register is free or being taken
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input register
    logic              p1_valid_reg;
    cmd_t              p1_cmd_reg;
    logic [NOTE_W-1:0] p1_note_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic [LOG2_W-1:0] p1_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (adv)
            p1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cmd_reg  <= cmd_t'(s_tuser);
            p1_note_reg <= s_tdata[15:0];
            p1_idx_reg  <= s_tdata[19:16];
            p1_log2_reg <= s_tdata[35:20];
        end
    end

    // equal pitch and the magnitude to divide
    logic [22:0]       eq_y;
    logic [46:0]       eq_prod;
    ntf_item_t         dv_in;

    assign eq_y    = {p1_note_reg[NOTE_W-1], p1_note_reg, 6'b0} + EQ_BIAS_Y;
    assign eq_prod = 47'(eq_y) * 47'(EQ_RECIP);

    always_comb
    begin
        dv_in.cmd      = p1_cmd_reg;
        dv_in.idx      = p1_idx_reg;
        dv_in.log2     = p1_log2_reg;
        dv_in.frac     = p1_note_reg[FRAC_W-1:0];
        dv_in.neg      = p1_note_reg[NOTE_W-1];
        dv_in.mag      = p1_note_reg[NOTE_W-1] ? (~p1_note_reg[NOTE_W-1:FRAC_W] + 1'b1)
                                               : p1_note_reg[NOTE_W-1:FRAC_W];
        dv_in.eq_pitch = $signed({3'b0, eq_prod[EQ_SHIFT+21:EQ_SHIFT]}) - EQ_BIAS_Q;
    end

    logic                  dv_valid;
    ntf_item_t             dv_item;
    logic [NOTE_INT_W-1:0] dv_quo;
    logic [STEPS_W-1:0]    dv_rem;

    ntf_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p1_valid_reg),
        .in_item   (dv_in),
        .divisor   (steps_eff),
        .out_valid (dv_valid),
        .out_item  (dv_item),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem)
    );

    // floor division fix-up: octave and step within the octave
    logic signed [OCT_W-1:0] oct;
    logic [STEP_IDX_W-1:0]   step;
    logic                    last_step;
    logic [OCT_W-1:0]        quo_ext;
    logic [STEPS_W-1:0]      steps_less;
    tbl_req_t                tbl_req;

    assign quo_ext    = {1'b0, dv_quo};
    assign steps_less = steps_eff - STEPS_W'(dv_rem);

    always_comb
    begin
        if (dv_item.neg && dv_rem != '0)
        begin
            oct  = $signed(~quo_ext);
            step = steps_less[STEP_IDX_W-1:0];
        end
        else if (dv_item.neg)
        begin
            oct  = $signed(~quo_ext + 1'b1);
            step = '0;
        end
        else
        begin
            oct  = $signed(quo_ext);
            step = dv_rem[STEP_IDX_W-1:0];
        end
    end

    assign last_step = ({1'b0, step} == (steps_eff - 1'b1));

    always_comb
    begin
        tbl_req.wr_en    = adv && dv_valid && (dv_item.cmd == CMD_WRITE);
        tbl_req.wr_addr  = dv_item.idx;
        tbl_req.wr_data  = dv_item.log2;
        tbl_req.rd_en    = adv;
        tbl_req.rd_addr0 = step;
        tbl_req.rd_addr1 = last_step ? step : (step + 1'b1);
    end

    logic [LOG2_W-1:0] rd_cur;
    logic [LOG2_W-1:0] rd_nxt;

    ntf_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table
    (
        .clk      (clk),
        .req      (tbl_req),
        .rd_data0 (rd_cur),
        .rd_data1 (rd_nxt)
    );

    // stage alongside the table read data
    logic                       p10_valid_reg;
    cmd_t                       p10_cmd_reg;
    logic [FRAC_W-1:0]          p10_frac_reg;
    logic signed [OCT_W-1:0]    p10_oct_reg;
    logic                       p10_last_reg;
    logic signed [PITCH_W-1:0]  p10_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p10_valid_reg <= 1'b0;
        else if (adv)
            p10_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_cmd_reg  <= dv_item.cmd;
            p10_frac_reg <= dv_item.frac;
            p10_oct_reg  <= oct;
            p10_last_reg <= last_step;
            p10_eq_reg   <= dv_item.eq_pitch;
        end
    end

    // log-linear interpolation toward the next step, or the octave
    logic [16:0]               nxt_val;
    logic [24:0]               lerp_sum;
    logic signed [PITCH_W-1:0] tab_pitch;
    logic signed [PITCH_W-1:0] pitch_next;

    assign nxt_val    = p10_last_reg ? OCTAVE_Q16 : {1'b0, rd_nxt};
    assign lerp_sum   = 25'(rd_cur) * 25'(9'd256 - {1'b0, p10_frac_reg})
                      + 25'(nxt_val) * 25'(p10_frac_reg);
    assign tab_pitch  = $signed({p10_oct_reg, 16'b0}) + $signed({8'b0, lerp_sum[24:8]});
    assign pitch_next = (mode_reg == MODE_TABLE) ? tab_pitch : p10_eq_reg;

    logic                      p11_valid_reg;
    cmd_t                      p11_cmd_reg;
    logic signed [PITCH_W-1:0] p11_pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p11_valid_reg <= 1'b0;
        else if (adv)
            p11_valid_reg <= p10_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p11_cmd_reg   <= p10_cmd_reg;
            p11_pitch_reg <= pitch_next;
        end
    end

    ntf_exp2 #(.EXP_ROM_BITS(EXP_ROM_BITS)) u_exp2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p11_valid_reg),
        .in_cmd    (p11_cmd_reg),
        .in_pitch  (p11_pitch_reg),
        .root      (root_reg),
        .out_valid (m_tvalid),
        .out_freq  (m_tdata),
        .out_sat   (m_tuser)
    );

    // a clamped result is always the full-scale value
    a_sat_is_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("saturated result without full-scale frequency");

    // input side only stalls behind an untaken result
    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output register is free");

    // a table write item keeps its place in the pipeline
    a_write_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        p10_valid_reg && p10_cmd_reg == CMD_WRITE && adv
        |=> p11_valid_reg && p11_cmd_reg == CMD_WRITE)
        else $error("table write item lost between stages");

endmodule
